// ===== src/polyphase_filterbank_fir_front_end_assert.svh =====
// assertion macros used by the port-level checker file
`ifndef POLYPHASE_FILTERBANK_FIR_FRONT_END_ASSERT_SVH
`define POLYPHASE_FILTERBANK_FIR_FRONT_END_ASSERT_SVH

// plain property, disabled while reset is active
`define PFB_ASSERT(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// antecedent implies consequent in the next cycle
`define PFB_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== src/pfb_pkg.sv =====
// shared constants, types and helper functions of the polyphase fir stage
package pfb_pkg;

  localparam int MAX_CHANNELS = 512;
  localparam int MAX_TAPS     = 8;
  localparam int STORE_DEPTH  = MAX_CHANNELS * MAX_TAPS;

  localparam int ADDR_W = $clog2(STORE_DEPTH);
  localparam int CH_W   = $clog2(MAX_CHANNELS);
  localparam int NC_W   = $clog2(MAX_CHANNELS + 1);
  localparam int TAP_W  = (MAX_TAPS > 1) ? $clog2(MAX_TAPS) : 1;
  localparam int NT_W   = $clog2(MAX_TAPS + 1);
  localparam int MAC_AW = TAP_W + NC_W + 1;

  localparam int COEFF_IDX_W = 12;
  localparam int COEFF_W     = 16;
  localparam int SAMPLE_W    = 16;
  localparam int RING_W      = 2 * SAMPLE_W;
  localparam int PROD_W      = SAMPLE_W + COEFF_W;
  localparam int ACC_W       = 34;
  localparam int OUT_CH_W    = 9;

  localparam int CFG_IDX_W  = 4;
  localparam int CFG_DATA_W = 16;
  localparam int CFG_NC_W   = 10;
  localparam int CFG_NT_W   = 4;

  localparam logic [CFG_NC_W-1:0] NUM_CHANNELS_RST = CFG_NC_W'(512);
  localparam logic [CFG_NT_W-1:0] NUM_TAPS_RST     = CFG_NT_W'(8);

  localparam logic [CFG_IDX_W-1:0] REG_NUM_CHANNELS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] REG_NUM_TAPS     = CFG_IDX_W'(1);

  typedef enum logic {
    OP_LOAD   = 1'b0,
    OP_SAMPLE = 1'b1
  } op_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_WAIT,
    ST_FINISH
  } ctrl_state_e;

  typedef struct packed {
    logic              clear;
    logic [ADDR_W-1:0] clear_addr;
    logic              wr_coeff;
    logic              wr_sample;
    logic              rd_issue;
    logic [TAP_W-1:0]  tap;
    logic              first_tap;
    logic              last_tap;
    logic              load_out;
  } cmd_t;

  typedef struct packed {
    logic            acc_done;
    logic            out_free;
    logic [NT_W-1:0] num_taps;
  } sts_t;

  // out-of-range register values are pulled into the legal range
  function automatic logic [NC_W-1:0] eff_channels(input logic [CFG_NC_W-1:0] raw);
    logic [NC_W-1:0] r;
    if (raw == '0) begin
      r = NC_W'(1);
    end else if (int'(raw) > MAX_CHANNELS) begin
      r = NC_W'(MAX_CHANNELS);
    end else begin
      r = NC_W'(raw);
    end
    return r;
  endfunction

  function automatic logic [NT_W-1:0] eff_taps(input logic [CFG_NT_W-1:0] raw);
    logic [NT_W-1:0] r;
    if (raw == '0) begin
      r = NT_W'(1);
    end else if (int'(raw) > MAX_TAPS) begin
      r = NT_W'(MAX_TAPS);
    end else begin
      r = NT_W'(raw);
    end
    return r;
  endfunction

endpackage

// ===== src/pfb_if.sv =====
// channel interfaces: input items, configuration writes, result items
interface pfb_in_if;
  logic                                valid;
  logic                                ready;
  logic                                op;
  logic [pfb_pkg::COEFF_IDX_W-1:0]     coeff_index;
  logic signed [pfb_pkg::COEFF_W-1:0]  coeff_value;
  logic signed [pfb_pkg::SAMPLE_W-1:0] sample_re;
  logic signed [pfb_pkg::SAMPLE_W-1:0] sample_im;

  modport source (output valid, op, coeff_index, coeff_value, sample_re, sample_im,
                  input ready);
  modport sink (input valid, op, coeff_index, coeff_value, sample_re, sample_im,
                output ready);
endinterface

interface pfb_cfg_if;
  logic                            valid;
  logic                            ready;
  logic [pfb_pkg::CFG_IDX_W-1:0]   index;
  logic [pfb_pkg::CFG_DATA_W-1:0]  data;

  modport source (output valid, index, data, input ready);
  modport sink (input valid, index, data, output ready);
endinterface

interface pfb_out_if;
  logic                             valid;
  logic                             ready;
  logic [pfb_pkg::OUT_CH_W-1:0]     channel;
  logic signed [pfb_pkg::ACC_W-1:0] filtered_re;
  logic signed [pfb_pkg::ACC_W-1:0] filtered_im;
  logic                             last_channel;

  modport source (output valid, channel, filtered_re, filtered_im, last_channel,
                  input ready);
  modport sink (input valid, channel, filtered_re, filtered_im, last_channel,
                output ready);
endinterface

// ===== src/polyphase_filterbank_fir_front_end.sv =====
// top level of the polyphase filter-bank fir stage
//
//  channel  | dir | payload
//  ---------+-----+------------------------------------------------------
//  in_i     | in  | op, coeff_index, coeff_value, sample_re, sample_im
//  cfg_i    | in  | index (0 num_channels, 1 num_taps), data
//  out_o    | out | channel, filtered_re, filtered_im, last_channel
//
// a coefficient load leaves the input open for the next item; a sample closes it until
// its result is loaded, one tap read a cycle from the single-port ring memory into the shared mac
// after reset a clearing pass zeroes all 4096 ring entries; in_i.ready stays low then
// configuration writes are taken in every cycle, cfg_i.ready is always high
// a result waits in the output register while the next item is taken; a stalled
// result holds back only the end of the following sample
module polyphase_filterbank_fir_front_end (
  input logic       clk_i,
  input logic       rst_ni,
  pfb_in_if.sink    in_i,
  pfb_cfg_if.sink   cfg_i,
  pfb_out_if.source out_o
);

  pfb_pkg::cmd_t cmd;
  pfb_pkg::sts_t sts;

  assign cfg_i.ready = 1'b1;

  pfb_ctrl u_ctrl (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .in_valid_i(in_i.valid),
    .in_op_i   (in_i.op),
    .in_ready_o(in_i.ready),
    .sts_i     (sts),
    .cmd_o     (cmd)
  );

  pfb_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .cfg_valid_i  (cfg_i.valid),
    .cfg_index_i  (cfg_i.index),
    .cfg_data_i   (cfg_i.data),
    .coeff_index_i(in_i.coeff_index),
    .coeff_value_i(in_i.coeff_value),
    .sample_re_i  (in_i.sample_re),
    .sample_im_i  (in_i.sample_im),
    .out_ready_i  (out_o.ready),
    .out_valid_o  (out_o.valid),
    .out_channel_o(out_o.channel),
    .out_re_o     (out_o.filtered_re),
    .out_im_o     (out_o.filtered_im),
    .out_last_o   (out_o.last_channel)
  );

endmodule

// ===== src/pfb_ram.sv =====
// generic single-port ram with registered read
module pfb_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 4096
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    rdata_q <= mem_q[addr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== src/pfb_ctrl.sv =====
// sequencer: ring clearing pass, item accept, tap reads, result hand-off
module pfb_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  input  logic          in_op_i,
  output logic          in_ready_o,
  input  pfb_pkg::sts_t sts_i,
  output pfb_pkg::cmd_t cmd_o
);

  localparam logic [pfb_pkg::ADDR_W-1:0] ClrLast = pfb_pkg::ADDR_W'(pfb_pkg::STORE_DEPTH - 1);

  pfb_pkg::ctrl_state_e state_q, state_d;
  logic [pfb_pkg::TAP_W-1:0]  tap_q;
  logic [pfb_pkg::ADDR_W-1:0] clr_addr_q;
  logic                       last_tap;
  logic                       is_sample;

  assign last_tap  = (tap_q == pfb_pkg::TAP_W'(sts_i.num_taps - pfb_pkg::NT_W'(1)));
  assign is_sample = (in_op_i == pfb_pkg::OP_SAMPLE);

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      pfb_pkg::ST_CLEAR: begin
        if (clr_addr_q == ClrLast) state_d = pfb_pkg::ST_IDLE;
      end
      pfb_pkg::ST_IDLE: begin
        if (in_valid_i && is_sample) state_d = pfb_pkg::ST_READ;
      end
      pfb_pkg::ST_READ: begin
        if (last_tap) state_d = pfb_pkg::ST_WAIT;
      end
      pfb_pkg::ST_WAIT: begin
        if (sts_i.acc_done) state_d = pfb_pkg::ST_FINISH;
      end
      pfb_pkg::ST_FINISH: begin
        if (sts_i.out_free) state_d = pfb_pkg::ST_IDLE;
      end
      default: state_d = pfb_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.tap        = tap_q;
    cmd_o.clear_addr = clr_addr_q;
    in_ready_o       = 1'b0;
    unique case (state_q)
      pfb_pkg::ST_CLEAR: begin
        cmd_o.clear = 1'b1;
      end
      pfb_pkg::ST_IDLE: begin
        in_ready_o      = 1'b1;
        cmd_o.wr_coeff  = in_valid_i && !is_sample;
        cmd_o.wr_sample = in_valid_i && is_sample;
      end
      pfb_pkg::ST_READ: begin
        cmd_o.rd_issue  = 1'b1;
        cmd_o.first_tap = (tap_q == '0);
        cmd_o.last_tap  = last_tap;
      end
      pfb_pkg::ST_WAIT: begin
      end
      pfb_pkg::ST_FINISH: begin
        cmd_o.load_out = sts_i.out_free;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q    <= pfb_pkg::ST_CLEAR;
      tap_q      <= '0;
      clr_addr_q <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == pfb_pkg::ST_CLEAR) clr_addr_q <= clr_addr_q + pfb_pkg::ADDR_W'(1);
      if (state_q == pfb_pkg::ST_IDLE) begin
        tap_q <= '0;
      end else if (state_q == pfb_pkg::ST_READ) begin
        tap_q <= tap_q + pfb_pkg::TAP_W'(1);
      end
    end
  end

endmodule

// ===== src/pfb_datapath.sv =====
// datapath: config registers, ring and coefficient memories, shared mac, result register
module pfb_datapath (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  pfb_pkg::cmd_t                       cmd_i,
  output pfb_pkg::sts_t                       sts_o,
  input  logic                                cfg_valid_i,
  input  logic [pfb_pkg::CFG_IDX_W-1:0]       cfg_index_i,
  input  logic [pfb_pkg::CFG_DATA_W-1:0]      cfg_data_i,
  input  logic [pfb_pkg::COEFF_IDX_W-1:0]     coeff_index_i,
  input  logic signed [pfb_pkg::COEFF_W-1:0]  coeff_value_i,
  input  logic signed [pfb_pkg::SAMPLE_W-1:0] sample_re_i,
  input  logic signed [pfb_pkg::SAMPLE_W-1:0] sample_im_i,
  input  logic                                out_ready_i,
  output logic                                out_valid_o,
  output logic [pfb_pkg::OUT_CH_W-1:0]        out_channel_o,
  output logic signed [pfb_pkg::ACC_W-1:0]    out_re_o,
  output logic signed [pfb_pkg::ACC_W-1:0]    out_im_o,
  output logic                                out_last_o
);

  localparam int AW = pfb_pkg::MAC_AW;

  logic [pfb_pkg::CFG_NC_W-1:0] num_channels_q;
  logic [pfb_pkg::CFG_NT_W-1:0] num_taps_q;
  logic [pfb_pkg::NC_W-1:0]     nc;
  logic [pfb_pkg::NT_W-1:0]     nt;
  logic [pfb_pkg::CH_W-1:0]     ch_q;
  logic [pfb_pkg::TAP_W-1:0]    oldest_q;
  logic [pfb_pkg::TAP_W-1:0]    slot_q;
  logic                         last_ch;
  logic                         cfg_hit;

  logic [AW-1:0]                wr_full, rd_full, cf_full;
  logic [pfb_pkg::ADDR_W-1:0]   ring_addr, coeff_addr;
  logic [pfb_pkg::RING_W-1:0]   ring_wdata, ring_rdata;
  logic                         ring_we, coeff_we, coeff_in_range;
  logic [pfb_pkg::COEFF_W-1:0]  coeff_rdata;

  logic                             v1_q, first1_q, last1_q;
  logic                             v2_q, first2_q, last2_q;
  logic signed [pfb_pkg::PROD_W-1:0] prod_re_q, prod_im_q;
  logic signed [pfb_pkg::ACC_W-1:0]  acc_re_q, acc_im_q;
  logic                             acc_done_q;

  logic                             out_valid_q, out_last_q;
  logic [pfb_pkg::OUT_CH_W-1:0]     out_channel_q;
  logic signed [pfb_pkg::ACC_W-1:0] out_re_q, out_im_q;

  function automatic logic [pfb_pkg::TAP_W-1:0] next_slot(
    input logic [pfb_pkg::TAP_W-1:0] s,
    input logic [pfb_pkg::NT_W-1:0]  n
  );
    logic [pfb_pkg::NT_W:0] inc;
    inc = (pfb_pkg::NT_W+1)'(s) + (pfb_pkg::NT_W+1)'(1);
    return (inc == (pfb_pkg::NT_W+1)'(n)) ? '0 : pfb_pkg::TAP_W'(inc);
  endfunction

  assign nc      = pfb_pkg::eff_channels(num_channels_q);
  assign nt      = pfb_pkg::eff_taps(num_taps_q);
  assign last_ch = ((pfb_pkg::NC_W'(ch_q) + pfb_pkg::NC_W'(1)) == nc);
  assign cfg_hit = cfg_valid_i &&
                   ((cfg_index_i == pfb_pkg::REG_NUM_CHANNELS) ||
                    (cfg_index_i == pfb_pkg::REG_NUM_TAPS));

  // ring and coefficient addresses: slot or tap times channel count plus channel
  assign wr_full = AW'(oldest_q) * AW'(nc) + AW'(ch_q);
  assign rd_full = AW'(slot_q) * AW'(nc) + AW'(ch_q);
  assign cf_full = AW'(cmd_i.tap) * AW'(nc) + AW'(ch_q);

  always_comb begin
    if (cmd_i.clear) begin
      ring_addr = cmd_i.clear_addr;
    end else if (cmd_i.wr_sample) begin
      ring_addr = pfb_pkg::ADDR_W'(wr_full);
    end else begin
      ring_addr = pfb_pkg::ADDR_W'(rd_full);
    end
  end

  assign ring_we    = cmd_i.clear || cmd_i.wr_sample;
  assign ring_wdata = cmd_i.clear ? '0 : {sample_re_i, sample_im_i};

  assign coeff_in_range = (int'(coeff_index_i) < pfb_pkg::STORE_DEPTH);
  assign coeff_we       = cmd_i.wr_coeff && coeff_in_range;
  assign coeff_addr     = cmd_i.wr_coeff ? pfb_pkg::ADDR_W'(coeff_index_i)
                                         : pfb_pkg::ADDR_W'(cf_full);

  pfb_ram #(
    .WIDTH(pfb_pkg::RING_W),
    .DEPTH(pfb_pkg::STORE_DEPTH)
  ) u_ring_ram (
    .clk_i  (clk_i),
    .we_i   (ring_we),
    .addr_i (ring_addr),
    .wdata_i(ring_wdata),
    .rdata_o(ring_rdata)
  );

  pfb_ram #(
    .WIDTH(pfb_pkg::COEFF_W),
    .DEPTH(pfb_pkg::STORE_DEPTH)
  ) u_coeff_ram (
    .clk_i  (clk_i),
    .we_i   (coeff_we),
    .addr_i (coeff_addr),
    .wdata_i(coeff_value_i),
    .rdata_o(coeff_rdata)
  );

  // config registers and block position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      num_channels_q <= pfb_pkg::NUM_CHANNELS_RST;
      num_taps_q     <= pfb_pkg::NUM_TAPS_RST;
      ch_q           <= '0;
      oldest_q       <= '0;
      slot_q         <= '0;
    end else begin
      if (cfg_valid_i && (cfg_index_i == pfb_pkg::REG_NUM_CHANNELS)) begin
        num_channels_q <= cfg_data_i[pfb_pkg::CFG_NC_W-1:0];
      end
      if (cfg_valid_i && (cfg_index_i == pfb_pkg::REG_NUM_TAPS)) begin
        num_taps_q <= cfg_data_i[pfb_pkg::CFG_NT_W-1:0];
      end
      if (cfg_hit) begin
        ch_q     <= '0;
        oldest_q <= '0;
      end else if (cmd_i.load_out) begin
        if (last_ch) begin
          ch_q     <= '0;
          oldest_q <= next_slot(oldest_q, nt);
        end else begin
          ch_q <= ch_q + pfb_pkg::CH_W'(1);
        end
      end
      // tap 0 reads the slot after the one just written
      if (cmd_i.wr_sample) begin
        slot_q <= next_slot(oldest_q, nt);
      end else if (cmd_i.rd_issue) begin
        slot_q <= next_slot(slot_q, nt);
      end
    end
  end

  // mac pipeline: memory read, product, accumulate
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q       <= 1'b0;
      v2_q       <= 1'b0;
      acc_done_q <= 1'b0;
    end else begin
      v1_q       <= cmd_i.rd_issue;
      v2_q       <= v1_q;
      acc_done_q <= v2_q && last2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    first1_q  <= cmd_i.first_tap;
    last1_q   <= cmd_i.last_tap;
    first2_q  <= first1_q;
    last2_q   <= last1_q;
    prod_re_q <= $signed(ring_rdata[pfb_pkg::RING_W-1:pfb_pkg::SAMPLE_W]) *
                 $signed(coeff_rdata);
    prod_im_q <= $signed(ring_rdata[pfb_pkg::SAMPLE_W-1:0]) * $signed(coeff_rdata);
    if (v2_q) begin
      if (first2_q) begin
        acc_re_q <= pfb_pkg::ACC_W'(prod_re_q);
        acc_im_q <= pfb_pkg::ACC_W'(prod_im_q);
      end else begin
        acc_re_q <= acc_re_q + pfb_pkg::ACC_W'(prod_re_q);
        acc_im_q <= acc_im_q + pfb_pkg::ACC_W'(prod_im_q);
      end
    end
  end

  // result register, frees the input side while a result waits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.load_out) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_out) begin
      out_channel_q <= pfb_pkg::OUT_CH_W'(ch_q);
      out_last_q    <= last_ch;
      out_re_q      <= acc_re_q;
      out_im_q      <= acc_im_q;
    end
  end

  assign sts_o.acc_done = acc_done_q;
  assign sts_o.out_free = !out_valid_q || out_ready_i;
  assign sts_o.num_taps = nt;

  assign out_valid_o   = out_valid_q;
  assign out_channel_o = out_channel_q;
  assign out_re_o      = out_re_q;
  assign out_im_o      = out_im_q;
  assign out_last_o    = out_last_q;

endmodule

// ===== src/pfb_checker.sv =====
// port-level checker for the polyphase fir stage, bound to the top level
`include "polyphase_filterbank_fir_front_end_assert.svh"

module pfb_checker (
  input logic                                clk_i,
  input logic                                rst_ni,
  input logic                                in_valid_i,
  input logic                                in_ready_i,
  input logic                                in_op_i,
  input logic                                out_valid_i,
  input logic                                out_ready_i,
  input logic [pfb_pkg::OUT_CH_W-1:0]        out_channel_i,
  input logic signed [pfb_pkg::ACC_W-1:0]    out_re_i,
  input logic signed [pfb_pkg::ACC_W-1:0]    out_im_i,
  input logic                                out_last_i
);

  // a stalled result holds its value
  `PFB_ASSERT_NEXT(a_out_hold, clk_i, rst_ni, out_valid_i && !out_ready_i, out_valid_i && $stable(out_channel_i) && $stable(out_re_i) && $stable(out_im_i) && $stable(out_last_i), "stalled result changed")

  // after an accepted sample transaction the input is closed
  `PFB_ASSERT_NEXT(a_sample_busy, clk_i, rst_ni, in_valid_i && in_ready_i && in_op_i, !in_ready_i, "input reopened during sample")

  // a coefficient load does not close the input
  `PFB_ASSERT_NEXT(a_load_fast, clk_i, rst_ni, in_valid_i && in_ready_i && !in_op_i, in_ready_i, "coefficient load stalled input")

  // a new result comes only from a sample in progress
  `PFB_ASSERT(a_out_from_work, clk_i, rst_ni, $rose(out_valid_i) |-> $past(!in_ready_i), "result without sample in progress")

endmodule

bind polyphase_filterbank_fir_front_end pfb_checker u_pfb_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .in_valid_i   (in_i.valid),
  .in_ready_i   (in_i.ready),
  .in_op_i      (in_i.op),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_channel_i(out_o.channel),
  .out_re_i     (out_o.filtered_re),
  .out_im_i     (out_o.filtered_im),
  .out_last_i   (out_o.last_channel)
);
